[rtl/core/assert_macros.svh]
// Assertion helpers shared by the RTL that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Antecedent implies consequent in the cycle after.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

[rtl/core/swbm_pkg.sv]
package swbm_pkg;

  // Default record store depth.
  localparam int unsigned DEFAULT_FIFO_DEPTH = 64;

  // Field widths.
  localparam int unsigned BYTES_W  = 16;
  localparam int unsigned STAMP_W  = 32;
  localparam int unsigned WINDOW_W = 31;
  localparam int unsigned WBYTES_W = 22;
  localparam int unsigned HELD_W   = 7;

  // Window length after reset, in microsecond ticks.
  localparam logic [WINDOW_W-1:0] WINDOW_RESET = 31'd1000000;

  // Input kinds carried in tuser.
  localparam logic OP_TICK        = 1'b0;
  localparam logic OP_TRANSACTION = 1'b1;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_CHECK
  } state_e;

endpackage

[rtl/core/sliding_window_byte_meter.sv]
// Sliding-window byte meter. Each input transfer is either a one-microsecond
// tick (tuser = 0) or a transaction of byte_count bytes (tuser = 1). A
// transaction is stamped with the current time and queued; when the record
// store already holds FIFO_DEPTH records it is dropped and the result's
// overflow flag is set. After every input, records older than window_length
// ticks are retired oldest first. Every input yields one result: bytes and
// records still in the window, plus the overflow flag. An item goes from idle
// through fetch and check, and again through both per record it retires; the
// retire loop is bound by the single registered read port of the record
// memory, one record per read. The record memory needs no clearing, so inputs
// are taken right after reset. A result waiting on the output stalls the meter
// in check; window_length may be rewritten only while the meter is idle.
module sliding_window_byte_meter
  import swbm_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = DEFAULT_FIFO_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration: window_length
  input  logic                cfg_we_i,
  input  logic [WINDOW_W-1:0] cfg_wdata_i,
  // Input stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [15:0]         s_axis_tdata,   // [15:0] byte_count
  input  logic                s_axis_tuser,   // [0] operation
  // Result stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [31:0]         m_axis_tdata,   // [21:0] window_bytes, [28:22] records_held
  output logic                m_axis_tuser    // [0] overflow
);

  `include "assert_macros.svh"

  localparam int unsigned PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned TOT_W = (BYTES_W + CNT_W > WBYTES_W + 1) ?
                                  BYTES_W + CNT_W : WBYTES_W + 1;
  localparam int unsigned SCN_W = (CNT_W > HELD_W) ? CNT_W : HELD_W + 1;
  localparam int unsigned REC_W = BYTES_W + STAMP_W;

  localparam logic [PTR_W-1:0] PTR_LAST   = PTR_W'(FIFO_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL   = CNT_W'(FIFO_DEPTH);
  localparam logic [TOT_W-1:0] TOT_SAT    = TOT_W'({WBYTES_W{1'b1}});
  localparam logic [SCN_W-1:0] HELD_SAT   = SCN_W'({HELD_W{1'b1}});

  state_e state_q, state_d;

  logic [WINDOW_W-1:0] window_q;
  logic [STAMP_W-1:0]  time_q, time_d;
  logic [PTR_W-1:0]    head_q, head_d;
  logic [PTR_W-1:0]    tail_q, tail_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [TOT_W-1:0]    total_q, total_d;
  logic                refused_q, refused_d;

  logic [REC_W-1:0]    mem_q [FIFO_DEPTH];
  logic [REC_W-1:0]    rd_q;

  logic                out_valid_q, out_valid_d;
  logic [WBYTES_W-1:0] out_bytes_q;
  logic [HELD_W-1:0]   out_held_q;
  logic                out_ovf_q;

  logic                accept;
  logic                full;
  logic                wr_en;
  logic                expire;
  logic                pop;
  logic                out_free;
  logic                out_load;
  logic [BYTES_W-1:0]  rd_size;
  logic [STAMP_W-1:0]  rd_stamp;
  logic [STAMP_W-1:0]  age;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign full     = (count_q == CNT_FULL);
  assign rd_size  = rd_q[BYTES_W-1:0];
  assign rd_stamp = rd_q[REC_W-1:BYTES_W];
  assign age      = time_q - rd_stamp;
  assign expire   = (count_q != '0) && (age > {1'b0, window_q});
  assign out_free = !out_valid_q || m_axis_tready;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_FETCH;
      end
      ST_FETCH: begin
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (expire) state_d = ST_FETCH;
        else if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    s_axis_tready = 1'b0;
    wr_en         = 1'b0;
    pop           = 1'b0;
    out_load      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        wr_en         = s_axis_tvalid && (s_axis_tuser == OP_TRANSACTION) && !full;
      end
      ST_FETCH: ;
      ST_CHECK: begin
        pop      = expire;
        out_load = !expire && out_free;
      end
      default: ;
    endcase
  end

  // Pointer, count, total and time updates
  always_comb begin
    time_d    = time_q;
    head_d    = head_q;
    tail_d    = tail_q;
    count_d   = count_q;
    total_d   = total_q;
    refused_d = refused_q;
    if (accept) begin
      refused_d = (s_axis_tuser == OP_TRANSACTION) && full;
      if (s_axis_tuser == OP_TICK) time_d = time_q + 1'b1;
    end
    if (wr_en) begin
      head_d  = (head_q == PTR_LAST) ? '0 : head_q + 1'b1;
      count_d = count_q + 1'b1;
      total_d = total_q + TOT_W'(s_axis_tdata);
    end
    if (pop) begin
      tail_d  = (tail_q == PTR_LAST) ? '0 : tail_q + 1'b1;
      count_d = count_q - 1'b1;
      total_d = total_q - TOT_W'(rd_size);
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      window_q    <= WINDOW_RESET;
      time_q      <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      total_q     <= '0;
      refused_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      time_q      <= time_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      total_q     <= total_d;
      refused_q   <= refused_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) window_q <= cfg_wdata_i;
    end
  end

  // Record memory: write at head on each stored transaction, registered read at tail
  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[head_q] <= {time_q, s_axis_tdata};
    rd_q <= mem_q[tail_q];
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) out_valid_d = 1'b1;
    else if (m_axis_tready) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_bytes_q <= (total_q > TOT_SAT) ? {WBYTES_W{1'b1}} : total_q[WBYTES_W-1:0];
      out_held_q  <= (SCN_W'(count_q) > HELD_SAT) ? {HELD_W{1'b1}}
                                                  : HELD_W'(SCN_W'(count_q));
      out_ovf_q   <= refused_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_held_q, out_bytes_q};
  assign m_axis_tuser  = out_ovf_q;

  // Checks
  `ASSERT_ALWAYS(a_count_bound, clk_i, rst_ni, count_q <= CNT_FULL, "record count above depth")
  `ASSERT_ALWAYS(a_pop_nonempty, clk_i, rst_ni, !pop || (count_q != '0), "retire from empty store")
  `ASSERT_NEXT(a_push_count, clk_i, rst_ni, wr_en && !pop, count_q == $past(count_q) + 1'b1, "push lost")
  `ASSERT_ALWAYS(a_load_free, clk_i, rst_ni, !out_load || out_free, "result overwritten")

endmodule

[sim/tb_sliding_window_byte_meter.sv]
module tb_sliding_window_byte_meter;
  timeunit 1ns;
  timeprecision 1ps;

  import swbm_pkg::*;

  localparam int unsigned DEPTH           = DEFAULT_FIFO_DEPTH;
  localparam int unsigned LIMIT_CYCLES    = 1_000_000;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned HOLD_OFF_AT     = 500;
  localparam int unsigned DRAIN_CYCLES    = 2 * DEPTH + 16;
  localparam int unsigned PHASE_ITEMS     = 240;
  localparam int unsigned NUM_PHASES      = 7;

  // One meter reading as it leaves the block
  typedef struct packed {
    logic [WBYTES_W-1:0] window_bytes;
    logic [HELD_W-1:0]   records_held;
    logic                overflow;
  } reading_t;

  typedef enum logic {
    ROW_INPUT,
    ROW_WINDOW
  } row_kind_e;

  // Directed plan: input rows repeat reps times; fixed readings only where obvious
  typedef struct {
    row_kind_e           kind;
    logic [WINDOW_W-1:0] window;
    logic                op;
    logic [BYTES_W-1:0]  nbytes;
    int unsigned         reps;
    logic                fixed;
    reading_t            want;
  } plan_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we = 1'b0;
  logic [WINDOW_W-1:0] cfg_wdata = '0;
  logic                s_valid = 1'b0;
  logic                s_axis_tready;
  logic [15:0]         s_tdata = '0;
  logic                s_tuser = OP_TICK;
  logic                m_axis_tvalid;
  logic                m_ready = 1'b0;
  logic [31:0]         m_axis_tdata;
  logic                m_axis_tuser;

  sliding_window_byte_meter i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .s_axis_tvalid(s_valid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_tdata),
    .s_axis_tuser (s_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_ready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Meter state mirror
  logic [BYTES_W-1:0]  rec_size  [DEPTH];
  logic [STAMP_W-1:0]  rec_stamp [DEPTH];
  int unsigned         rd_ptr = 0;
  int unsigned         wr_ptr = 0;
  int unsigned         held = 0;
  logic [22:0]         byte_sum = '0;
  logic [STAMP_W-1:0]  now_us = '0;
  logic [WINDOW_W-1:0] window_us = WINDOW_RESET;

  reading_t    pending_readings[$];
  int unsigned mismatch_cnt = 0;
  int unsigned results_seen = 0;
  int unsigned burst_left = 0;

  // Advance the mirror by one input and return the reading it produces
  function automatic reading_t meter_step(logic op, logic [BYTES_W-1:0] nbytes);
    reading_t           r;
    logic [STAMP_W-1:0] age;
    r.overflow = 1'b0;
    if (op == OP_TICK) begin
      now_us = now_us + 1;
    end else if (held >= DEPTH) begin
      r.overflow = 1'b1;
    end else begin
      rec_size[wr_ptr]  = nbytes;
      rec_stamp[wr_ptr] = now_us;
      wr_ptr   = (wr_ptr + 1) % DEPTH;
      held     = held + 1;
      byte_sum = byte_sum + nbytes;
    end
    // retire expired records, oldest first
    while (held > 0) begin
      age = now_us - rec_stamp[rd_ptr];
      if (age <= {1'b0, window_us}) break;
      byte_sum = byte_sum - rec_size[rd_ptr];
      rd_ptr   = (rd_ptr + 1) % DEPTH;
      held     = held - 1;
    end
    r.window_bytes = (byte_sum > 23'h3FFFFF) ? '1 : byte_sum[WBYTES_W-1:0];
    r.records_held = (held > 127) ? '1 : HELD_W'(held);
    return r;
  endfunction

  // Offer one input in bursts with random gaps; called at a falling edge
  task automatic offer(logic op, logic [BYTES_W-1:0] nbytes, logic fixed, reading_t want);
    int unsigned gap;
    reading_t    got;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        s_valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
    end
    burst_left = burst_left - 1;
    s_valid <= 1'b1;
    s_tdata <= nbytes;
    s_tuser <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    got = meter_step(op, nbytes);
    pending_readings.push_back(fixed ? want : got);
    @(negedge clk_i);
  endtask

  // Window rewrite only once the meter has drained
  task automatic write_window(logic [WINDOW_W-1:0] w);
    s_valid <= 1'b0;
    while (pending_readings.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= w;
    window_us = w;
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Result side: own stall pattern plus one long hold-off
  initial begin
    bit          held_off;
    int unsigned run;
    int unsigned stall;
    held_off = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (!held_off && results_seen >= HOLD_OFF_AT) begin
        held_off = 1'b1;
        m_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk_i);
      end
      run = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 120) : $urandom_range(1, 20);
      m_ready <= 1'b1;
      repeat (run) @(negedge clk_i);
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (stall != 0) begin
        m_ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
    end
  end

  // Compare each result transfer against the oldest expected reading
  always @(posedge clk_i) begin : check_results
    reading_t want;
    if (rst_ni && m_axis_tvalid && m_ready) begin
      results_seen = results_seen + 1;
      if (pending_readings.size() == 0) begin
        $error("result transfer with no reading expected");
        mismatch_cnt = mismatch_cnt + 1;
      end else begin
        want = pending_readings.pop_front();
        if (m_axis_tdata[21:0] !== want.window_bytes) begin
          $error("window_bytes: expected %0d, actual %0d", want.window_bytes,
                 m_axis_tdata[21:0]);
          mismatch_cnt = mismatch_cnt + 1;
        end
        if (m_axis_tdata[28:22] !== want.records_held) begin
          $error("records_held: expected %0d, actual %0d", want.records_held,
                 m_axis_tdata[28:22]);
          mismatch_cnt = mismatch_cnt + 1;
        end
        if (m_axis_tuser !== want.overflow) begin
          $error("overflow: expected %0d, actual %0d", want.overflow, m_axis_tuser);
          mismatch_cnt = mismatch_cnt + 1;
        end
      end
    end
  end

  // Watchdog
  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycles = cycles + 1;
    end
    $display("end of test: mismatches");
    $finish;
  end

  // Stimulus
  initial begin
    plan_row_t           plan[$];
    plan_row_t           row;
    int unsigned         phase_window [NUM_PHASES];
    int unsigned         phase_tick_pct [NUM_PHASES];
    logic                op;
    logic [BYTES_W-1:0]  nbytes;

    // after reset: empty meter, default window
    plan.push_back('{ROW_INPUT, '0, OP_TICK, 16'hFFFF, 1, 1'b1, '{22'd0, 7'd0, 1'b0}});
    plan.push_back('{ROW_INPUT, '0, OP_TRANSACTION, 16'h0000, 1, 1'b1,
                     '{22'd0, 7'd1, 1'b0}});
    // fill the store with largest transactions
    plan.push_back('{ROW_INPUT, '0, OP_TRANSACTION, 16'hFFFF, DEPTH - 1, 1'b0, '0});
    // full store refuses the next transaction
    plan.push_back('{ROW_INPUT, '0, OP_TRANSACTION, 16'hFFFF, 1, 1'b1,
                     '{22'd4128705, 7'd64, 1'b1}});
    plan.push_back('{ROW_INPUT, '0, OP_TICK, 16'h0000, 1, 1'b1,
                     '{22'd4128705, 7'd64, 1'b0}});
    // zero window: new window takes effect at the next input, all records expire
    plan.push_back('{ROW_WINDOW, '0, OP_TICK, '0, 0, 1'b0, '0});
    plan.push_back('{ROW_INPUT, '0, OP_TICK, 16'h1234, 1, 1'b1, '{22'd0, 7'd0, 1'b0}});
    plan.push_back('{ROW_INPUT, '0, OP_TRANSACTION, 16'h5A5A, 1, 1'b1,
                     '{22'd23130, 7'd1, 1'b0}});
    plan.push_back('{ROW_INPUT, '0, OP_TICK, 16'h0000, 1, 1'b1, '{22'd0, 7'd0, 1'b0}});
    // short window, records retire one by one
    plan.push_back('{ROW_WINDOW, 31'd2, OP_TICK, '0, 0, 1'b0, '0});
    plan.push_back('{ROW_INPUT, '0, OP_TRANSACTION, 16'h8001, 1, 1'b0, '0});
    plan.push_back('{ROW_INPUT, '0, OP_TICK, 16'hA5A5, 1, 1'b0, '0});
    plan.push_back('{ROW_INPUT, '0, OP_TRANSACTION, 16'h7FFE, 1, 1'b0, '0});
    plan.push_back('{ROW_INPUT, '0, OP_TICK, 16'h0000, 4, 1'b0, '0});
    // widest window
    plan.push_back('{ROW_WINDOW, 31'h7FFFFFFF, OP_TICK, '0, 0, 1'b0, '0});
    plan.push_back('{ROW_INPUT, '0, OP_TRANSACTION, 16'hFFFF, 1, 1'b0, '0});
    plan.push_back('{ROW_INPUT, '0, OP_TICK, 16'h5555, 3, 1'b0, '0});
    plan.push_back('{ROW_INPUT, '0, OP_TRANSACTION, 16'h0001, 1, 1'b0, '0});

    phase_window   = '{1, 0, 6, 40, 300, 32'h7FFFFFFF, $urandom_range(2, 100)};
    phase_tick_pct = '{50, 50, 30, 10, 5, 40, 25};

    rst_ni <= 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (plan[i]) begin
      row = plan[i];
      if (row.kind == ROW_WINDOW) begin
        write_window(row.window);
      end else begin
        repeat (row.reps) offer(row.op, row.nbytes, row.fixed, row.want);
      end
    end

    // random phases, one window setting each
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_window(phase_window[p][WINDOW_W-1:0]);
      repeat (PHASE_ITEMS) begin
        op = ($urandom_range(1, 100) <= phase_tick_pct[p]) ? OP_TICK : OP_TRANSACTION;
        case ($urandom_range(0, 7))
          0:       nbytes = 16'h0000;
          1:       nbytes = 16'hFFFF;
          default: nbytes = BYTES_W'($urandom);
        endcase
        offer(op, nbytes, 1'b0, '0);
      end
    end

    s_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending_readings.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
